>>> hdl/ust_pkg.sv
// Shared types and codes for the unordered set table.
package ust_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  // Command from the controller to every cell of the row.
  typedef struct packed {
    logic        write_last;  // the cell at the fill index takes the value
    logic        move_last;   // the matching cell takes the last member
    logic [31:0] value;
  } ust_cmd_t;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) begin
      ieee_eq = 1'b0;
    end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
      ieee_eq = 1'b1;
    end else begin
      ieee_eq = (a == b);
    end
  endfunction

endpackage

>>> hdl/ust_cell.sv
// One slot of the table: holds a member and compares it with the request value.
module ust_cell (
  input  logic              clk,
  input  logic              occupied,
  input  logic              is_last,
  input  logic              is_fill,
  input  ust_pkg::ust_cmd_t cmd,
  input  logic [31:0]       last_value,
  output logic [31:0]       entry,
  output logic              match
);

  logic [31:0] entry_r;

  assign entry = entry_r;
  assign match = occupied && ust_pkg::ieee_eq(cmd.value, entry_r);

  always_ff @(posedge clk) begin
    if (cmd.write_last && is_fill) begin
      entry_r <= cmd.value;
    end else if (cmd.move_last && match && !is_last) begin
      entry_r <= last_value;
    end
  end

endmodule

>>> hdl/unordered_set_table.sv
// Each transaction passes through S_IDLE and S_UPD: the request is registered in S_IDLE; in
// S_UPD every cell compares the value with its member, a priority search picks the lowest
// matching slot, and at the end of S_UPD an inserted value is stored or the last member
// is moved into a removed slot, while the result register takes the answer and holds it until
// the out side takes it. A new transaction is taken only once the state is back in S_IDLE
// and no registered result is held by out_stall, so transactions never overlap.
// The table has no clearing pass after reset.
module unordered_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_found,
  output logic [5:0]  out_position,
  output logic [6:0]  out_occupancy
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [1:0]        kind_r;
  logic [31:0]       value_r;
  ust_pkg::ust_cmd_t cmd;
  logic [31:0]       entries [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic              found_c;
  logic [IW-1:0]     slot_c;
  logic [IW-1:0]     last_idx, fill_idx;
  logic [2:0]        status_c;
  logic [CW-1:0]     pos_c;

  assign in_stall = (state_r != S_IDLE) || (out_valid && out_stall);
  assign last_idx = IW'(count_r - CW'(1));
  assign fill_idx = IW'(count_r);

  always_comb begin
    found_c = 1'b0;
    slot_c  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_c = 1'b1;
        slot_c  = IW'(i);
      end
    end
  end

  always_comb begin
    status_c  = ust_pkg::ST_OK;
    pos_c     = found_c ? CW'(slot_c) : '0;
    count_nxt = count_r;
    cmd.value      = value_r;
    cmd.write_last = 1'b0;
    cmd.move_last  = 1'b0;
    case (kind_r)
      ust_pkg::KIND_INSERT: begin
        if (count_r >= CW'(CAPACITY)) begin
          status_c = ust_pkg::ST_FULL;
        end else if (found_c) begin
          status_c = ust_pkg::ST_DUP;
        end else begin
          pos_c     = count_r;
          count_nxt = count_r + CW'(1);
        end
      end
      ust_pkg::KIND_REMOVE: begin
        if (count_r == '0) begin
          status_c = ust_pkg::ST_EMPTY;
        end else if (!found_c) begin
          status_c = ust_pkg::ST_ABSENT;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        if (!found_c) status_c = ust_pkg::ST_ABSENT;
      end
    endcase
    if (state_r == S_UPD && kind_r == ust_pkg::KIND_INSERT && status_c == ust_pkg::ST_OK)
      cmd.write_last = 1'b1;
    if (state_r == S_UPD && kind_r == ust_pkg::KIND_REMOVE && status_c == ust_pkg::ST_OK)
      cmd.move_last = 1'b1;
  end

  // The cell command is driven in the update cycle from the compare of that same cycle.
  ust_pkg::ust_cmd_t cell_cmd;
  logic              found_r;
  logic [IW-1:0]     slot_r;

  always_comb begin
    cell_cmd = cmd;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ust_cell u_cell (
      .clk        (clk),
      .occupied   (CW'(g) < count_r),
      .is_last    (IW'(g) == last_idx),
      .is_fill    (IW'(g) == fill_idx),
      .cmd        (cell_cmd),
      .last_value (entries[last_idx]),
      .entry      (entries[g]),
      .match      (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            kind_r  <= in_kind;
            value_r <= in_value;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          count_r       <= count_nxt;
          out_valid     <= 1'b1;
          out_status    <= status_c;
          out_found     <= found_c;
          out_position  <= 6'(pos_c);
          out_occupancy <= 7'(count_nxt);
          found_r       <= found_c;
          slot_r        <= slot_c;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("member count beyond capacity");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> count_r == $past(count_r) || count_r == $past(count_r) + CW'(1)
      || count_r == $past(count_r) - CW'(1)) else $error("count moved by more than one");
  a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && found_r |-> slot_r < IW'(CAPACITY - 1) || slot_r == IW'(CAPACITY - 1))
    else $error("match slot out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> in_stall) else $error("transaction taken while busy");

endmodule
